>>> rtl/core/crdf_pkg.sv
package crdf_pkg;

    localparam logic [15:0] CRC_POLY          = 16'h1021;
    localparam logic [15:0] LENGTH_LIMIT_RST  = 16'd1024;

    typedef enum logic [5:0] {
        PH_LEN_LO = 6'b000001,
        PH_LEN_HI = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_SUM_LO = 6'b001000,
        PH_SUM_HI = 6'b010000,
        PH_HALT   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        RK_BYTE = 2'd0,
        RK_OK   = 2'd1,
        RK_ERR  = 2'd2,
        RK_END  = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_LENGTH  = 2'd1,
        ERR_PAYLOAD = 2'd2,
        ERR_CRC     = 2'd3
    } error_code_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] record_length;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // CRC-16/XMODEM table entry for one index byte, MSB first
    function automatic logic [15:0] crc_tab(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        return {crc[7:0], 8'h00} ^ crc_tab(crc[15:8] ^ b);
    endfunction

endpackage

>>> rtl/core/crc16_record_deframer.sv
// Record deframer for a byte stream of length-prefixed records, each closed by a
// CRC-16/XMODEM of its payload. One word is accepted per cycle while s_ready is high:
// the parse state, the byte counter and the CRC (one table lookup per byte) are
// updated in the cycle a word is accepted, and any result appears on the m_
// channel on the next cycle unless an earlier result is still waiting there. A
// two-entry output buffer (result register plus skid register) lets s_ready stay
// high while one result waits; s_ready drops only when both entries are full.
// After an error the block drops all input until aresetn. cfg_wr_en writes
// length_limit and is meant for idle periods.
module crc16_record_deframer
    import crdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_stream_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_record_length,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    logic [15:0] length_limit_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] length_value_reg, length_value_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  checksum_low_reg, checksum_low_next;

    result_t     out_reg, skid_reg, res_next;
    logic        out_valid_reg, skid_valid_reg, res_valid;

    logic        accept;
    logic [15:0] full_length;
    logic [15:0] sum;

    assign s_ready     = !skid_valid_reg;
    assign accept      = s_valid && s_ready;
    assign full_length = {s_stream_byte, length_value_reg[7:0]};
    assign sum         = {s_stream_byte, checksum_low_reg};

    always_comb begin
        phase_next        = phase_reg;
        length_value_next = length_value_reg;
        bytes_left_next   = bytes_left_reg;
        crc_next          = crc_reg;
        checksum_low_next = checksum_low_reg;
        res_valid         = 1'b0;
        res_next          = '{result_kind: RK_BYTE, payload_byte: 8'h00,
                              record_length: 16'h0000, error_code: ERR_NONE, last: 1'b1};
        if (s_kind == KIND_EOS) begin
            unique case (phase_reg)
                PH_LEN_LO: begin
                    length_value_next    = 16'h0000;
                    res_valid            = 1'b1;
                    res_next.result_kind = RK_END;
                end
                PH_LEN_HI: begin
                    phase_next           = PH_HALT;
                    res_valid            = 1'b1;
                    res_next.result_kind = RK_ERR;
                    res_next.error_code  = ERR_LENGTH;
                end
                PH_DATA: begin
                    phase_next             = PH_HALT;
                    res_valid              = 1'b1;
                    res_next.result_kind   = RK_ERR;
                    res_next.record_length = length_value_reg;
                    res_next.error_code    = ERR_PAYLOAD;
                end
                PH_SUM_LO, PH_SUM_HI: begin
                    phase_next             = PH_HALT;
                    res_valid              = 1'b1;
                    res_next.result_kind   = RK_ERR;
                    res_next.record_length = length_value_reg;
                    res_next.error_code    = ERR_CRC;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (phase_reg)
                PH_LEN_LO: begin
                    length_value_next = {8'h00, s_stream_byte};
                    phase_next        = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    length_value_next = full_length;
                    if (full_length >= length_limit_reg) begin
                        phase_next             = PH_HALT;
                        res_valid              = 1'b1;
                        res_next.result_kind   = RK_ERR;
                        res_next.record_length = full_length;
                        res_next.error_code    = ERR_LENGTH;
                    end else begin
                        crc_next        = 16'h0000;
                        bytes_left_next = full_length;
                        phase_next      = (full_length == 16'h0000) ? PH_SUM_LO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    crc_next        = crc_update(crc_reg, s_stream_byte);
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1) begin
                        phase_next = PH_SUM_LO;
                    end
                    res_valid              = 1'b1;
                    res_next.result_kind   = RK_BYTE;
                    res_next.payload_byte  = s_stream_byte;
                    res_next.record_length = length_value_reg;
                    res_next.last          = 1'b0;
                end
                PH_SUM_LO: begin
                    checksum_low_next = s_stream_byte;
                    phase_next        = PH_SUM_HI;
                end
                PH_SUM_HI: begin
                    res_valid              = 1'b1;
                    res_next.record_length = length_value_reg;
                    if (sum != crc_reg) begin
                        phase_next          = PH_HALT;
                        res_next.result_kind = RK_ERR;
                        res_next.error_code  = ERR_CRC;
                    end else begin
                        phase_next           = PH_LEN_LO;
                        res_next.result_kind = RK_OK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_limit_reg <= LENGTH_LIMIT_RST;
            phase_reg        <= PH_LEN_LO;
            length_value_reg <= 16'h0000;
            bytes_left_reg   <= 16'h0000;
            crc_reg          <= 16'h0000;
            checksum_low_reg <= 8'h00;
        end else begin
            if (cfg_wr_en) begin
                length_limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg        <= phase_next;
                length_value_reg <= length_value_next;
                bytes_left_reg   <= bytes_left_next;
                crc_reg          <= crc_next;
                checksum_low_reg <= checksum_low_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            // hold the result; park a new one in the skid entry
            if (accept && res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (accept && res_valid) begin
                skid_reg <= res_next;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else begin
            out_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_reg.result_kind;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_record_length = out_reg.record_length;
    assign m_error_code    = out_reg.error_code;
    assign m_last          = out_reg.last;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("left halted phase without reset");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != 16'h0000)
        else $error("payload phase with no bytes left");

    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.result_kind == RK_BYTE |->
            !out_reg.last && out_reg.error_code == ERR_NONE)
        else $error("payload word carries status fields");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_next.result_kind == RK_ERR |=> phase_reg == PH_HALT)
        else $error("error reported without halting");

endmodule
